// ===== sv/mkdh_pkg.sv =====
// Package for the multi-key debounce block.
// Holds the shared constants, register indexes and the structs that pass between modules.
// It depends on nothing.
package mkdh_pkg;

  localparam int KEYS      = 13;  // keys with a state machine, 1..13
  localparam int KEY_BITS  = 13;  // width of the pin and result vectors
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TIME    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIME  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_DELAY = CFG_IDX_W'(3);

  localparam logic [CFG_W-1:0] PRESS_TIME_RST    = CFG_W'(50);
  localparam logic [CFG_W-1:0] RELEASE_TIME_RST  = CFG_W'(50);
  localparam logic [CFG_W-1:0] HOLD_TIME_RST     = CFG_W'(900);
  localparam logic [CFG_W-1:0] STARTUP_DELAY_RST = CFG_W'(500);

  typedef struct packed {
    logic [CFG_W-1:0] press_time;
    logic [CFG_W-1:0] release_time;
    logic [CFG_W-1:0] hold_time;
    logic [CFG_W-1:0] startup_delay;
  } cfg_t;

  // What one key lane reports for the item being accepted.
  typedef struct packed {
    logic press_evt;
    logic stable;
    logic held;
  } lane_res_t;

endpackage

// ===== sv/mkdh_lane.sv =====
// One key lane: the five-state debounce and long-press machine for one key.
// Holds the key's phase and time stamp; uses mkdh_pkg.
module mkdh_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        down,
  input  logic [mkdh_pkg::TIME_W-1:0] now_ms,
  input  mkdh_pkg::cfg_t              cfg,
  output mkdh_pkg::lane_res_t         res
);

  typedef enum logic [2:0] {
    PH_RELEASED   = 3'd0,
    PH_PRESS_WAIT = 3'd1,
    PH_PRESSED    = 3'd2,
    PH_HOLD       = 3'd3,
    PH_REL_WAIT   = 3'd4
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [mkdh_pkg::TIME_W-1:0] stamp_r, stamp_nxt;
  logic [mkdh_pkg::TIME_W-1:0] dt;
  logic                        evt;

  assign dt = now_ms - stamp_r;

  always_comb begin
    phase_nxt = phase_r;
    stamp_nxt = stamp_r;
    evt       = 1'b0;
    case (phase_r)
      PH_RELEASED: begin
        if (down) begin
          phase_nxt = PH_PRESS_WAIT;
          stamp_nxt = now_ms;
        end
      end
      PH_PRESS_WAIT: begin
        if (dt > {16'b0, cfg.press_time}) begin
          phase_nxt = down ? PH_PRESSED : PH_RELEASED;
          evt       = down;
        end
      end
      PH_PRESSED: begin
        if (!down) begin
          phase_nxt = PH_REL_WAIT;
          stamp_nxt = now_ms;
        end else if (dt > {16'b0, cfg.hold_time}) begin
          // stamp still holds the time of the first press
          phase_nxt = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (!down) begin
          phase_nxt = PH_REL_WAIT;
          stamp_nxt = now_ms;
        end
      end
      PH_REL_WAIT: begin
        if (dt > {16'b0, cfg.release_time}) phase_nxt = PH_RELEASED;
      end
      default: begin
        phase_nxt = PH_RELEASED;
        if (down) begin
          phase_nxt = PH_PRESS_WAIT;
          stamp_nxt = now_ms;
        end
      end
    endcase
  end

  assign res.press_evt = evt;
  assign res.stable    = (phase_nxt == PH_PRESSED) || (phase_nxt == PH_HOLD);
  assign res.held      = (phase_nxt == PH_HOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  // stamp is written on leaving released before any read
  always_ff @(posedge clk) begin
    if (step) begin
      stamp_r <= stamp_nxt;
    end
  end

endmodule

// ===== sv/mkdh_merge.sv =====
// Merge stage: gathers the lane results into the result vectors, tracks the
// startup lock and holds the output register. Uses mkdh_pkg.
module mkdh_merge (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    step,
  input  logic                                    take,
  input  mkdh_pkg::lane_res_t [mkdh_pkg::KEYS-1:0] lane_res,
  input  logic [mkdh_pkg::KEY_BITS-1:0]           down_lv,
  input  logic [mkdh_pkg::TIME_W-1:0]             now_ms,
  input  logic [mkdh_pkg::CFG_W-1:0]              startup_delay,
  output logic                                    valid,
  output logic [mkdh_pkg::KEY_BITS-1:0]           press_events,
  output logic [mkdh_pkg::KEY_BITS-1:0]           down_levels,
  output logic [mkdh_pkg::KEY_BITS-1:0]           stable_pressed,
  output logic [mkdh_pkg::KEY_BITS-1:0]           held_keys,
  output logic                                    startup_locked
);

  logic                          valid_r;
  logic                          first_seen_r;
  logic [mkdh_pkg::TIME_W-1:0]   sstamp_r;
  logic                          lock_r, lock_nxt;
  logic [mkdh_pkg::TIME_W-1:0]   sstamp_eff;
  logic [mkdh_pkg::KEY_BITS-1:0] evt_v, stb_v, hld_v;
  logic [mkdh_pkg::KEY_BITS-1:0] evt_r, down_r, stb_r, hld_r;

  always_comb begin
    evt_v = '0;
    stb_v = '0;
    hld_v = '0;
    for (int k = 0; k < mkdh_pkg::KEYS; k++) begin
      evt_v[k] = lane_res[k].press_evt;
      stb_v[k] = lane_res[k].stable;
      hld_v[k] = lane_res[k].held;
    end
  end

  // first item stamps itself, so its difference is zero
  assign sstamp_eff = first_seen_r ? sstamp_r : now_ms;
  assign lock_nxt   = lock_r && !((now_ms - sstamp_eff) > {16'b0, startup_delay});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      first_seen_r <= 1'b0;
      sstamp_r     <= '0;
      lock_r       <= 1'b1;
    end else begin
      if (step) begin
        valid_r      <= 1'b1;
        first_seen_r <= 1'b1;
        sstamp_r     <= sstamp_eff;
        lock_r       <= lock_nxt;
      end else if (take) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      evt_r  <= evt_v;
      down_r <= down_lv;
      stb_r  <= stb_v;
      hld_r  <= hld_v;
    end
  end

  assign valid          = valid_r;
  assign press_events   = evt_r;
  assign down_levels    = down_r;
  assign stable_pressed = stb_r;
  assign held_keys      = hld_r;
  assign startup_locked = lock_r;

endmodule

// ===== sv/multi_key_debounce_hold.sv =====
// Multi-key debounce with long-press detection, top level.
// Instantiates one mkdh_lane per key and the mkdh_merge stage; uses mkdh_pkg.
//
// Each item is one scan of up to 13 active-low key pins plus a wrapping
// millisecond time. Every key lane updates in the cycle the item is accepted
// and the result appears in the output register on the next cycle, so one
// scan per clock is sustained; the only stall comes from a full output
// register that is not being taken. Configuration registers (press, release,
// hold and startup times) may be written at any time the block is idle; the
// config port is always ready and ignores indexes beyond three.
module multi_key_debounce_hold (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mkdh_pkg::KEY_BITS-1:0]       in_pin_levels,
  input  logic [mkdh_pkg::TIME_W-1:0]         in_now_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mkdh_pkg::KEY_BITS-1:0]       out_press_events,
  output logic [mkdh_pkg::KEY_BITS-1:0]       out_down_levels,
  output logic [mkdh_pkg::KEY_BITS-1:0]       out_stable_pressed,
  output logic [mkdh_pkg::KEY_BITS-1:0]       out_held_keys,
  output logic                                out_startup_locked,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mkdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mkdh_pkg::CFG_W-1:0]          cfg_data
);

  mkdh_pkg::cfg_t                          cfg_r;
  mkdh_pkg::lane_res_t [mkdh_pkg::KEYS-1:0] lane_res;
  logic [mkdh_pkg::KEY_BITS-1:0]           down_lv;
  logic                                    step;
  logic                                    take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign step      = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_time    <= mkdh_pkg::PRESS_TIME_RST;
      cfg_r.release_time  <= mkdh_pkg::RELEASE_TIME_RST;
      cfg_r.hold_time     <= mkdh_pkg::HOLD_TIME_RST;
      cfg_r.startup_delay <= mkdh_pkg::STARTUP_DELAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mkdh_pkg::REG_PRESS_TIME:    cfg_r.press_time    <= cfg_data;
        mkdh_pkg::REG_RELEASE_TIME:  cfg_r.release_time  <= cfg_data;
        mkdh_pkg::REG_HOLD_TIME:     cfg_r.hold_time     <= cfg_data;
        mkdh_pkg::REG_STARTUP_DELAY: cfg_r.startup_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // pins beyond the configured key count read as released
  always_comb begin
    down_lv = '0;
    for (int k = 0; k < mkdh_pkg::KEYS; k++) begin
      down_lv[k] = !in_pin_levels[k];
    end
  end

  for (genvar k = 0; k < mkdh_pkg::KEYS; k++) begin : g_lane
    mkdh_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .step   (step),
      .down   (down_lv[k]),
      .now_ms (in_now_ms),
      .cfg    (cfg_r),
      .res    (lane_res[k])
    );
  end

  mkdh_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .take           (take),
    .lane_res       (lane_res),
    .down_lv        (down_lv),
    .now_ms         (in_now_ms),
    .startup_delay  (cfg_r.startup_delay),
    .valid          (out_valid),
    .press_events   (out_press_events),
    .down_levels    (out_down_levels),
    .stable_pressed (out_stable_pressed),
    .held_keys      (out_held_keys),
    .startup_locked (out_startup_locked)
  );

endmodule
